/* src/rpmc_pkg.sv */
// ----------------------------------------------------------------------------
// rpmc_pkg
// Types, codes and constants shared by the render power-mode controller.
// ----------------------------------------------------------------------------
package rpmc_pkg;

  // Field and counter widths.
  localparam int unsigned TimeoutW = 22;
  localparam int unsigned IdleW    = 22;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned PollW    = 13;
  localparam int unsigned PctW     = 8;
  localparam int unsigned CapW     = 10;
  localparam int unsigned ProdW    = FrameW + CapW;

  // Stream and register port widths.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RegDataW = 32;

  // Behavioural constants.
  localparam logic [PollW-1:0]   PollPeriodMs  = PollW'(5000);
  localparam logic [PctW-1:0]    LowBatteryPct = PctW'(20);
  localparam logic [PctW-1:0]    UnknownPct    = PctW'(255);
  localparam logic [CapW-1:0]    LowRateCap    = CapW'(10);
  localparam logic [ProdW-1:0]   MsPerSec      = ProdW'(1000);
  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(60000);

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] RegPausedTimeout   = 3'd0;
  localparam logic [2:0] RegPauseHidden     = 3'd1;
  localparam logic [2:0] RegPauseFullscreen = 3'd2;
  localparam logic [2:0] RegPauseBattery    = 3'd3;
  localparam logic [2:0] RegPauseLocked     = 3'd4;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpActivity = 2'd1,
    OpUpdate   = 2'd2,
    OpFrame    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ModeActive     = 3'd0,
    ModeLowRate    = 3'd1,
    ModePaused     = 3'd2,
    ModeOccluded   = 3'd3,
    ModeFullscreen = 3'd4,
    ModeBattery    = 3'd5,
    ModeLocked     = 3'd6,
    ModeRemote     = 3'd7
  } mode_e;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [TimeoutW-1:0] paused_timeout_ms;
    logic                pause_when_hidden;
    logic                pause_when_fullscreen;
    logic                pause_on_battery;
    logic                pause_when_locked;
  } cfg_t;

  // One input event.
  typedef struct packed {
    opcode_e         opcode;
    logic            session_locked;
    logic            remote_session;
    logic            ac_unplugged;
    logic            saver_flag;
    logic [PctW-1:0] battery_percent;
    logic            fullscreen_fg;
    logic            occluded;
    logic [CapW-1:0] fps_cap;
  } in_item_t;

  // Handshake between the input register and the engine.
  typedef struct packed {
    logic valid;
  } stage_hs_t;

endpackage

/* src/rpmc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rpmc_cfg_regs
// Register bank of the controller behind a simple APB-style port.
// ----------------------------------------------------------------------------
module rpmc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpmc_pkg::AddrW-1:0]      paddr,
  input  logic [rpmc_pkg::RegDataW-1:0]   pwdata,
  output logic [rpmc_pkg::RegDataW-1:0]   prdata,
  output logic                            pready,
  output rpmc_pkg::cfg_t                  cfg_o
);
  import rpmc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write decode; addresses outside the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPausedTimeout:   cfg_d.paused_timeout_ms     = pwdata[TimeoutW-1:0];
        RegPauseHidden:     cfg_d.pause_when_hidden     = pwdata[0];
        RegPauseFullscreen: cfg_d.pause_when_fullscreen = pwdata[0];
        RegPauseBattery:    cfg_d.pause_on_battery      = pwdata[0];
        RegPauseLocked:     cfg_d.pause_when_locked     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.paused_timeout_ms     <= TimeoutReset;
      cfg_q.pause_when_hidden     <= 1'b1;
      cfg_q.pause_when_fullscreen <= 1'b1;
      cfg_q.pause_on_battery      <= 1'b0;
      cfg_q.pause_when_locked     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegPausedTimeout:   prdata = RegDataW'(cfg_q.paused_timeout_ms);
      RegPauseHidden:     prdata = RegDataW'(cfg_q.pause_when_hidden);
      RegPauseFullscreen: prdata = RegDataW'(cfg_q.pause_when_fullscreen);
      RegPauseBattery:    prdata = RegDataW'(cfg_q.pause_on_battery);
      RegPauseLocked:     prdata = RegDataW'(cfg_q.pause_when_locked);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/rpmc_in_reg.sv */
// ----------------------------------------------------------------------------
// rpmc_in_reg
// Input register: captures one event beat and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module rpmc_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rpmc_pkg::in_item_t   in_item_i,
  input  logic                 take_i,
  output rpmc_pkg::stage_hs_t  hs_o,
  output rpmc_pkg::in_item_t   item_o
);
  import rpmc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // A new beat may enter when the register is empty or drains this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign hs_o.valid = valid_q;
  assign item_o     = item_q;

endmodule

/* src/rpmc_engine.sv */
// ----------------------------------------------------------------------------
// rpmc_engine
// Controller state, one-pass event evaluation and the result register.
// ----------------------------------------------------------------------------
module rpmc_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rpmc_pkg::cfg_t       cfg_i,
  input  rpmc_pkg::stage_hs_t  hs_i,
  input  rpmc_pkg::in_item_t   item_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpmc_pkg::mode_e      out_mode_o,
  output logic                 out_render_o
);
  import rpmc_pkg::*;

  mode_e             mode_q, mode_d;
  logic [IdleW-1:0]  idle_q, idle_d;
  logic [FrameW-1:0] frame_gap_q, frame_gap_d;
  logic [PollW-1:0]  poll_gap_q, poll_gap_d;
  logic              held_q, held_d;
  logic              polled_q, polled_d;
  logic              out_valid_q;
  mode_e             out_mode_q;
  logic              out_render_q;
  logic              render_d;

  logic              locked_exit, remote_exit, poll_due, poll_now;
  logic              sampled_saver, held_eff, timeout_on;
  logic              reach_pause, reach_low;
  logic [CapW-1:0]   cap;
  logic [ProdW-1:0]  gap_prod;
  logic              frame_ok;
  mode_e             picked;

  // The engine advances whenever an event waits and the result slot is free.
  assign take_o = hs_i.valid && (!out_valid_q || out_ready_i);

  // Update evaluation: exits by priority, battery poll in between.
  always_comb begin
    locked_exit   = cfg_i.pause_when_locked && item_i.session_locked;
    remote_exit   = cfg_i.pause_when_locked && item_i.remote_session;
    poll_due      = !polled_q || (poll_gap_q > PollPeriodMs);
    poll_now      = !locked_exit && !remote_exit && poll_due;
    sampled_saver = item_i.ac_unplugged &&
                    (item_i.saver_flag ||
                     ((item_i.battery_percent != UnknownPct) &&
                      (item_i.battery_percent < LowBatteryPct)));
    held_eff      = poll_now ? sampled_saver : held_q;
    timeout_on    = (cfg_i.paused_timeout_ms != '0);
    reach_pause   = timeout_on && (idle_q >= cfg_i.paused_timeout_ms);
    reach_low     = timeout_on &&
                    ({idle_q, 1'b0} >= {1'b0, cfg_i.paused_timeout_ms});
    priority if (locked_exit)                                   picked = ModeLocked;
    else if (remote_exit)                                       picked = ModeRemote;
    else if (cfg_i.pause_on_battery && held_eff)                picked = ModeBattery;
    else if (cfg_i.pause_when_fullscreen && item_i.fullscreen_fg) picked = ModeFullscreen;
    else if (cfg_i.pause_when_hidden && item_i.occluded)        picked = ModeOccluded;
    else if (reach_pause)                                       picked = ModePaused;
    else if (reach_low)                                         picked = ModeLowRate;
    else                                                        picked = ModeActive;
  end

  // Frame pacing: grant at cap 0 or ms x cap >= 1 s in active/low-rate mode.
  always_comb begin
    cap      = (mode_q == ModeLowRate) ? LowRateCap : item_i.fps_cap;
    gap_prod = ProdW'(frame_gap_q) * ProdW'(cap);
    frame_ok = ((mode_q == ModeActive) || (mode_q == ModeLowRate)) &&
               ((cap == '0) || (gap_prod >= MsPerSec));
  end

  // Next state for the event in the input register.
  always_comb begin
    mode_d      = mode_q;
    idle_d      = idle_q;
    frame_gap_d = frame_gap_q;
    poll_gap_d  = poll_gap_q;
    held_d      = held_q;
    polled_d    = polled_q;
    render_d    = 1'b0;
    if (take_o) begin
      unique case (item_i.opcode)
        OpTick: begin
          if (!(&idle_q))      idle_d      = idle_q + 1'b1;
          if (!(&frame_gap_q)) frame_gap_d = frame_gap_q + 1'b1;
          if (!(&poll_gap_q))  poll_gap_d  = poll_gap_q + 1'b1;
        end
        OpActivity: begin
          idle_d = '0;
          if ((mode_q == ModeLowRate) || (mode_q == ModePaused)) mode_d = ModeActive;
        end
        OpUpdate: begin
          mode_d = picked;
          if (poll_now) begin
            held_d     = sampled_saver;
            poll_gap_d = '0;
            polled_d   = 1'b1;
          end
        end
        OpFrame: begin
          render_d = frame_ok;
          if (frame_ok) frame_gap_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeActive;
      idle_q      <= '0;
      frame_gap_q <= '0;
      poll_gap_q  <= '0;
      held_q      <= 1'b0;
      polled_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      idle_q      <= idle_d;
      frame_gap_q <= frame_gap_d;
      poll_gap_q  <= poll_gap_d;
      held_q      <= held_d;
      polled_q    <= polled_d;
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: one result beat per event.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_mode_q   <= mode_d;
      out_render_q <= render_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_mode_o   = out_mode_q;
  assign out_render_o = out_render_q;

  // A granted frame only ever comes from an unpaused mode and resets the gap.
  a_grant_unpaused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && render_d |-> (mode_q == ModeActive) || (mode_q == ModeLowRate))
    else $error("frame granted while paused or hidden");

  a_grant_clears_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && render_d |=> frame_gap_q == '0)
    else $error("frame gap not cleared after a grant");

  // User activity always leaves the idle states behind.
  a_activity_wakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && (item_i.opcode == OpActivity) |=>
      (idle_q == '0) && (mode_q != ModeLowRate) && (mode_q != ModePaused))
    else $error("activity did not wake the controller");

  // A battery poll restarts the poll interval and marks the battery sampled.
  a_poll_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && (item_i.opcode == OpUpdate) && poll_now |=>
      (poll_gap_q == '0) && polled_q)
    else $error("battery poll did not restart its interval");

  // The result register never drops a beat that waits on a stalled receiver.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before it was taken");

endmodule

/* src/render_power_mode_controller_unit.sv */
// ----------------------------------------------------------------------------
// render_power_mode_controller_unit
// Power-mode controller for a renderer: event stream in, mode stream out.
// ----------------------------------------------------------------------------
// Events arrive on the slave stream, one per beat: tuser carries the opcode
// (tick of one millisecond, user activity, update evaluation, frame request)
// and tdata the session, battery, window flags and the requested frame cap.
// Every event yields exactly one result beat on the master stream with the
// power mode after the event and a frame grant flag.
// An accepted input beat waits in the input register; the evaluation then
// writes its result beat to the result register. Throughput is one event
// per cycle while the receiver takes every result, limited by the state
// update that each event performs in a single pass.
// If the receiver stalls, the held result waits in the result register and
// one further event may wait in the input register; tready then falls until
// the result is taken.
// Reset clears the mode to active, all counters and the battery poll
// history, and restores the register defaults. The APB-style port holds the
// pause timeout and the four pause enables; write it only while idle.
// ----------------------------------------------------------------------------
module render_power_mode_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Event stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: session_locked, remote_session, ac_unplugged, saver_flag,
  // battery_percent[7:0], fullscreen_fg, occluded, fps_cap[9:0].
  input  logic [rpmc_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [rpmc_pkg::InUserW-1:0]    s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: power_mode[2:0], render_now, zero pad.
  output logic [rpmc_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpmc_pkg::AddrW-1:0]      paddr,
  input  logic [rpmc_pkg::RegDataW-1:0]   pwdata,
  output logic [rpmc_pkg::RegDataW-1:0]   prdata,
  output logic                            pready
);
  import rpmc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item, held_item;
  stage_hs_t hs;
  logic      take;
  mode_e     out_mode;
  logic      out_render;

  // Unpack the event beat.
  always_comb begin
    in_item.opcode          = opcode_e'(s_axis_tuser);
    in_item.session_locked  = s_axis_tdata[0];
    in_item.remote_session  = s_axis_tdata[1];
    in_item.ac_unplugged    = s_axis_tdata[2];
    in_item.saver_flag      = s_axis_tdata[3];
    in_item.battery_percent = s_axis_tdata[11:4];
    in_item.fullscreen_fg   = s_axis_tdata[12];
    in_item.occluded        = s_axis_tdata[13];
    in_item.fps_cap         = s_axis_tdata[23:14];
  end

  rpmc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rpmc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (take),
    .hs_o       (hs),
    .item_o     (held_item)
  );

  rpmc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .hs_i         (hs),
    .item_i       (held_item),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_mode_o   (out_mode),
    .out_render_o (out_render)
  );

  // Pack the result beat.
  assign m_axis_tdata = {4'b0000, out_render, out_mode};

endmodule

/* verif/render_power_mode_controller_unit_tb.sv */
// ----------------------------------------------------------------------------
// render_power_mode_controller_unit_tb
// Self-checking bench for the render power-mode controller.
// ----------------------------------------------------------------------------
// Event beats are driven on the slave stream and every result beat is
// compared with a cycle-free model of the controller held in a scoreboard
// class. A directed opening walks through the mode priorities, frame
// pacing, the first battery poll and the idle modes. Randomised phases then
// run under a range of pause timeouts and pause enables, with random gaps on
// both streams, one long output stall and one stretch at full rate.
// ----------------------------------------------------------------------------
module render_power_mode_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpmc_pkg::*;

  localparam int unsigned CycleLimit   = 3000000;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned PhaseEvents  = 72;
  localparam int unsigned RxStallLen   = 300;

  // Mode predictor and store of expected result beats.
  typedef struct packed {
    mode_e mode;
    logic  render;
  } mode_beat_t;

  class power_mode_scoreboard;
    // Register copy.
    logic [TimeoutW-1:0] timeout_ms;
    logic                hide_en;
    logic                fullscreen_en;
    logic                battery_en;
    logic                lock_en;
    // Controller state.
    mode_e               mode;
    logic [IdleW-1:0]    idle_ms;
    logic [FrameW-1:0]   frame_gap_ms;
    logic [PollW-1:0]    poll_gap_ms;
    logic                saver_held;
    logic                polled;
    // Outstanding results and statistics.
    mode_beat_t          expected_modes[$];
    int unsigned         errors;
    int unsigned         events;
    int unsigned         results;
    int unsigned         grants;
    logic [7:0]          modes_seen;

    function new();
      timeout_ms    = TimeoutReset;
      hide_en       = 1'b1;
      fullscreen_en = 1'b1;
      battery_en    = 1'b0;
      lock_en       = 1'b1;
      mode          = ModeActive;
      idle_ms       = '0;
      frame_gap_ms  = '0;
      poll_gap_ms   = '0;
      saver_held    = 1'b0;
      polled        = 1'b0;
      errors        = 0;
      events        = 0;
      results       = 0;
      grants        = 0;
      modes_seen    = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [RegDataW-1:0] val);
      case (idx)
        RegPausedTimeout:   timeout_ms    = val[TimeoutW-1:0];
        RegPauseHidden:     hide_en       = val[0];
        RegPauseFullscreen: fullscreen_en = val[0];
        RegPauseBattery:    battery_en    = val[0];
        RegPauseLocked:     lock_en       = val[0];
        default: ;
      endcase
    endfunction

    // Mode selection by priority; the battery is sampled only when a poll is due.
    function mode_e select_mode(in_item_t ev);
      if (lock_en && ev.session_locked) return ModeLocked;
      if (lock_en && ev.remote_session) return ModeRemote;
      if (!polled || poll_gap_ms > PollPeriodMs) begin
        saver_held  = ev.ac_unplugged && (ev.saver_flag ||
                      (ev.battery_percent != UnknownPct && ev.battery_percent < LowBatteryPct));
        poll_gap_ms = '0;
        polled      = 1'b1;
      end
      if (battery_en && saver_held) return ModeBattery;
      if (fullscreen_en && ev.fullscreen_fg) return ModeFullscreen;
      if (hide_en && ev.occluded) return ModeOccluded;
      if (timeout_ms != '0 && idle_ms >= timeout_ms) return ModePaused;
      if (timeout_ms != '0 && {idle_ms, 1'b0} >= {1'b0, timeout_ms}) return ModeLowRate;
      return ModeActive;
    endfunction

    function void record_event(in_item_t ev);
      logic            grant;
      logic [CapW-1:0] cap;
      logic [ProdW-1:0] elapsed;
      grant = 1'b0;
      events++;
      case (ev.opcode)
        OpTick: begin
          if (idle_ms != '1) idle_ms = idle_ms + 1'b1;
          if (frame_gap_ms != '1) frame_gap_ms = frame_gap_ms + 1'b1;
          if (poll_gap_ms != '1) poll_gap_ms = poll_gap_ms + 1'b1;
        end
        OpActivity: begin
          idle_ms = '0;
          if (mode == ModeLowRate || mode == ModePaused) mode = ModeActive;
        end
        OpUpdate: mode = select_mode(ev);
        default: begin
          // Frames are paced only in the active and low-rate modes.
          if (mode == ModeActive || mode == ModeLowRate) begin
            cap     = (mode == ModeLowRate) ? LowRateCap : ev.fps_cap;
            elapsed = frame_gap_ms * cap;
            if (cap == '0 || elapsed >= MsPerSec) begin
              grant        = 1'b1;
              frame_gap_ms = '0;
              grants++;
            end
          end
        end
      endcase
      expected_modes.push_back('{mode: mode, render: grant});
    endfunction

    function void check_mode_beat(logic [OutDataW-1:0] data);
      mode_beat_t want;
      if (expected_modes.size() == 0) begin
        $display("%0t: result beat %h arrived with no event outstanding", $time, data);
        errors++;
        return;
      end
      want = expected_modes.pop_front();
      results++;
      modes_seen[data[2:0]] = 1'b1;
      if (data[2:0] != want.mode) begin
        $display("%0t: power_mode expected %0d, actual %0d", $time, want.mode, data[2:0]);
        errors++;
      end
      if (data[3] != want.render) begin
        $display("%0t: render_now expected %0b, actual %0b", $time, want.render, data[3]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_modes.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [InUserW-1:0]   s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [RegDataW-1:0]  pwdata;
  logic [RegDataW-1:0]  prdata;
  logic                 pready;

  power_mode_scoreboard sb;
  bit                   tx_steady    = 1'b0;
  bit                   rx_steady    = 1'b0;
  bit                   rx_stall_req = 1'b0;
  int unsigned          cycles       = 0;

  render_power_mode_controller_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock, 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watch both streams; every accepted event beat feeds the predictor.
  always @(posedge clk_i) begin
    in_item_t ev;
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ev.opcode          = opcode_e'(s_axis_tuser);
        ev.session_locked  = s_axis_tdata[0];
        ev.remote_session  = s_axis_tdata[1];
        ev.ac_unplugged    = s_axis_tdata[2];
        ev.saver_flag      = s_axis_tdata[3];
        ev.battery_percent = s_axis_tdata[11:4];
        ev.fullscreen_fg   = s_axis_tdata[12];
        ev.occluded        = s_axis_tdata[13];
        ev.fps_cap         = s_axis_tdata[23:14];
        sb.record_event(ev);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_mode_beat(m_axis_tdata);
    end
  end

  // Result receiver: random back-pressure, one long stall on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_stall_req) begin
        rx_stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RxStallLen) @(posedge clk_i);
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // Run limit.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one event beat, possibly after a random gap, and wait until taken.
  task automatic send_event(input in_item_t ev);
    if (!tx_steady && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.fps_cap, ev.occluded, ev.fullscreen_fg, ev.battery_percent,
                      ev.saver_flag, ev.ac_unplugged, ev.remote_session, ev.session_locked};
    s_axis_tuser  <= ev.opcode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic in_item_t ev_of(opcode_e op, logic lock, logic remote, logic unplug,
                                     logic saver, logic [PctW-1:0] pct, logic fs, logic occ,
                                     logic [CapW-1:0] cap);
    in_item_t ev;
    ev.opcode          = op;
    ev.session_locked  = lock;
    ev.remote_session  = remote;
    ev.ac_unplugged    = unplug;
    ev.saver_flag      = saver;
    ev.battery_percent = pct;
    ev.fullscreen_fg   = fs;
    ev.occluded        = occ;
    ev.fps_cap         = cap;
    return ev;
  endfunction

  task automatic tick_run(input int unsigned count);
    repeat (count) send_event(ev_of(OpTick, 0, 0, 0, 0, '0, 0, 0, '0));
  endtask

  // Random event with the flags weighted towards the interesting cases.
  function automatic in_item_t random_event();
    in_item_t    ev;
    int unsigned pick;
    ev.session_locked = ($urandom_range(0, 99) < 8);
    ev.remote_session = ($urandom_range(0, 99) < 8);
    ev.ac_unplugged   = 1'($urandom_range(0, 1));
    ev.saver_flag     = ($urandom_range(0, 99) < 25);
    ev.fullscreen_fg  = ($urandom_range(0, 99) < 15);
    ev.occluded       = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    if (pick < 42)      ev.opcode = OpTick;
    else if (pick < 50) ev.opcode = OpActivity;
    else if (pick < 78) ev.opcode = OpUpdate;
    else                ev.opcode = OpFrame;
    case ($urandom_range(0, 3))
      0:       ev.battery_percent = UnknownPct;
      1:       ev.battery_percent = PctW'($urandom_range(0, 25));
      default: ev.battery_percent = PctW'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       ev.fps_cap = '0;
      1:       ev.fps_cap = CapW'($urandom_range(1, 12));
      2:       ev.fps_cap = CapW'($urandom_range(1000, 1023));
      default: ev.fps_cap = CapW'($urandom_range(0, 1023));
    endcase
    return ev;
  endfunction

  // Register write: setup beat, then access beat.
  task automatic apb_write(input logic [2:0] idx, input logic [RegDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [TimeoutW-1:0] tmo, input logic [3:0] en);
    apb_write(RegPausedTimeout, RegDataW'(tmo));
    apb_write(RegPauseHidden, RegDataW'(en[0]));
    apb_write(RegPauseFullscreen, RegDataW'(en[1]));
    apb_write(RegPauseBattery, RegDataW'(en[2]));
    apb_write(RegPauseLocked, RegDataW'(en[3]));
  endtask

  // Stop offering beats and let every expected result come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned         n;
    int unsigned         burst;
    logic [TimeoutW-1:0] tmo;
    logic [3:0]          en;
    sb = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under the reset register values.
    send_event(ev_of(OpUpdate, 1, 1, 0, 0, 8'd255, 0, 0, '0));  // locked wins over remote
    send_event(ev_of(OpUpdate, 0, 1, 0, 0, 8'd255, 0, 0, '0));  // remote session
    send_event(ev_of(OpUpdate, 0, 0, 1, 0, 8'd19, 1, 1, '0));   // first poll, low battery
    send_event(ev_of(OpUpdate, 0, 0, 0, 0, 8'd0, 0, 1, '0));    // occluded
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, '0));       // denied while hidden
    send_event(ev_of(OpActivity, 0, 0, 0, 0, '0, 0, 0, '0));    // does not wake occluded
    send_event(ev_of(OpUpdate, 0, 0, 0, 0, 8'd255, 0, 0, '0));  // back to active
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd1000));
    tick_run(1);
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd1000)); // exactly one second
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd0));    // uncapped
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd1023));
    tick_run(1);
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd1023)); // cap above range
    wait_drained();

    // Short timeout, battery pause on, other pauses off; the saver condition
    // sampled at the first poll still holds.
    configure(22'd7, 4'b0100);
    send_event(ev_of(OpUpdate, 1, 1, 0, 0, 8'd20, 1, 1, '0));   // held saver condition
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, '0));       // denied in battery mode
    send_event(ev_of(OpActivity, 0, 0, 0, 0, '0, 0, 0, '0));    // does not wake battery mode
    tick_run(4);
    wait_drained();

    // Same timeout with every pause off: idle low rate, then idle paused.
    configure(22'd7, 4'b0000);
    send_event(ev_of(OpUpdate, 0, 0, 1, 0, 8'd20, 1, 1, '0));   // half timeout, low rate
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd1));    // low-rate cap applies
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, 10'd0));
    tick_run(4);
    send_event(ev_of(OpUpdate, 0, 0, 0, 0, 8'd255, 0, 0, '0));  // full timeout, paused
    send_event(ev_of(OpFrame, 0, 0, 0, 0, '0, 0, 0, '0));       // denied while paused
    send_event(ev_of(OpActivity, 0, 0, 0, 0, '0, 0, 0, '0));    // wakes to active
    wait_drained();

    // Randomised phases under a spread of register settings.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       tmo = 22'd1;
        1:       tmo = 22'd0;
        2:       tmo = 22'd2;
        3:       tmo = 22'd5;
        4:       tmo = 22'd3600000;
        5:       tmo = TimeoutW'($urandom_range(3, 40));
        6:       tmo = 22'h3FFFFF;
        7:       tmo = 22'd8;
        default: tmo = 22'd13;
      endcase
      if (ph == 0)      en = 4'b1111;
      else if (ph == 1) en = 4'b0000;
      else              en = 4'($urandom_range(0, 15));
      configure(tmo, en);
      if (ph == 3) rx_stall_req = 1'b1;
      if (ph == 5) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      n = 0;
      while (n < PhaseEvents) begin
        if ($urandom_range(0, 99) < 8) begin
          burst = $urandom_range(3, 25);
          tick_run(burst);
          n += burst;
        end else begin
          send_event(random_event());
          n++;
        end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      wait_drained();
    end

    $display("Checked %0d result beats for %0d event beats, %0d frames granted.",
             sb.results, sb.events, sb.grants);
    $display("Modes reached %b, timeouts 0 to 4194303, every pause enable both ways.",
             sb.modes_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
